// ----- hdl/ctb_pkg.sv -----
// Shared types and constants for the coupling tree builder.
package ctb_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 2;
  localparam int GRP_W  = 5 - LANE_W;
  localparam int NODE_W = 6;
  localparam int NODES  = 64;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_ORBIT  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_MERGE   = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_SPLIT   = 3'd3,
    KIND_BADSET  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WALK,
    S_DECIDE,
    S_MERGE_A,
    S_MERGE_B,
    S_FCHECK,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic              launch;
    logic              member;
    logic [NODE_W-1:0] leaf;
  } lane_ctl_t;

  typedef struct packed {
    logic              hit;
    logic              done;
    logic [NODE_W-1:0] root;
  } lane_st_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } wr_t;

endpackage

// ----- hdl/ctb_lane.sv -----
// Root walker lane with its own copy of the parent table.
module ctb_lane
  import ctb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  wr_t              wr,
  input  logic [NODES-1:0] pvalid,
  output lane_st_t         st
);

  logic [NODE_W-1:0] mem [NODES];
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] rdata;
  logic [NODE_W-1:0] addr;
  logic [6:0]        steps;
  logic              member;
  logic              halt;

  assign addr = ctl.launch ? ctl.leaf : rdata;
  assign halt = !pvalid[cur] || (steps == 7'(NODES));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member <= 1'b0;
      cur    <= '0;
      steps  <= '0;
    end else if (ctl.launch) begin
      member <= ctl.member;
      cur    <= ctl.leaf;
      steps  <= '0;
    end else if (member && !halt) begin
      cur   <= rdata;
      steps <= steps + 7'd1;
    end
  end

  assign st.hit  = member;
  assign st.done = !member || halt;
  assign st.root = cur;

endmodule

// ----- hdl/coupling_tree_builder_unit.sv -----
// Top level of the coupling tree builder: control, lanes and root merging.
//
// An item is taken when start is high and busy low; each result appears for one
// cycle with result_strobe and cannot be held off. Begin, unused and rejected
// commands give their single result in the cycle after acceptance. An orbit walks
// four member leaves at a time through the parent chains, one step per cycle per
// lane, so the chain depth sets how long it takes. A finish performs each join by
// scanning the active root bits one per cycle and writing the parent table in
// states S_MERGE_A and S_MERGE_B, for up to 31 joins. The parent table needs no
// clearing pass: begin clears its valid bits at once.
module coupling_tree_builder_unit
  import ctb_pkg::*;
#(
  parameter int MAX_LEAVES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] orbit_mask,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data,
  output logic        result_strobe,
  output logic [2:0]  kind,
  output logic [5:0]  left_node,
  output logic [5:0]  right_node,
  output logic [5:0]  result_node,
  output logic [4:0]  merges_done,
  output logic        last
);

  state_t            state, state_next;
  logic [NODES-1:0]  pvalid;
  logic [62:0]       active;
  logic [4:0]        mc;
  logic              err_hold;
  logic              started;
  logic [5:0]        n;
  logic [31:0]       mask;
  logic [GRP_W-1:0]  grp;
  logic [1:0]        cnt;
  logic [5:0]        r0, r1, ml, mr;
  logic              is_finish;
  logic [5:0]        scan;
  logic              have_a;

  lane_ctl_t         ctl [LANES];
  lane_st_t          lst [LANES];
  wr_t               wr;

  logic              n_ok, mc_full, all_done, grp_last;
  logic [5:0]        res, base;
  logic [1:0]        cnt_f;
  logic [5:0]        r0_f, r1_f;
  logic [62:0]       active_init;
  cmd_t              cmd_c;

  logic              emit, emit_last;
  kind_t             emit_kind;
  logic [5:0]        emit_l, emit_r, emit_res;
  logic [4:0]        emit_md;

  assign cmd_c    = cmd_t'(cmd);
  assign n_ok     = (n != 6'd0) && (n <= 6'(MAX_LEAVES));
  assign mc_full  = {1'b0, mc} >= (n - 6'd1);
  assign res      = n + {1'b0, mc};
  assign base     = {1'b0, grp, {LANE_W{1'b0}}};
  assign grp_last = (base + 6'(LANES)) >= n;

  always_comb begin
    for (int i = 0; i < 63; i++) begin
      active_init[i] = (i < int'(n));
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    always_comb begin
      ctl[j].launch = (state == S_LAUNCH);
      ctl[j].leaf   = base + 6'(j);
      ctl[j].member = mask[ctl[j].leaf[4:0]] && (ctl[j].leaf < n);
    end
    ctb_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl[j]),
      .wr     (wr),
      .pvalid (pvalid),
      .st     (lst[j])
    );
  end

  always_comb begin
    all_done = 1'b1;
    cnt_f    = cnt;
    r0_f     = r0;
    r1_f     = r1;
    for (int j = 0; j < LANES; j++) begin
      all_done = all_done && lst[j].done;
      if (lst[j].hit) begin
        if (cnt_f == 2'd0) begin
          r0_f  = lst[j].root;
          cnt_f = 2'd1;
        end else if (cnt_f == 2'd1 && lst[j].root != r0_f) begin
          r1_f  = lst[j].root;
          cnt_f = 2'd2;
        end else if (cnt_f == 2'd2 && lst[j].root != r0_f && lst[j].root != r1_f) begin
          cnt_f = 2'd3;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd_c == CMD_ORBIT && started && n_ok && !err_hold && !mc_full) begin
            state_next = S_LAUNCH;
          end else if (cmd_c == CMD_FINISH && started && n_ok && !err_hold) begin
            state_next = S_FCHECK;
          end
        end
      end
      S_LAUNCH: state_next = S_WALK;
      S_WALK: begin
        if (all_done) begin
          state_next = (cnt_f == 2'd3 || grp_last) ? S_DECIDE : S_LAUNCH;
        end
      end
      S_DECIDE:  state_next = (cnt == 2'd2) ? S_MERGE_A : S_IDLE;
      S_MERGE_A: state_next = S_MERGE_B;
      S_MERGE_B: state_next = is_finish ? S_FCHECK : S_IDLE;
      S_FCHECK:  state_next = mc_full ? S_IDLE : S_SCAN;
      S_SCAN: begin
        if (active[scan] && have_a) begin
          state_next = S_MERGE_A;
        end else if (scan == 6'd62) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    wr.en     = 1'b0;
    wr.addr   = ml;
    wr.data   = res;
    emit      = 1'b0;
    emit_kind = KIND_ACCEPT;
    emit_l    = '0;
    emit_r    = '0;
    emit_res  = '0;
    emit_md   = mc;
    emit_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_c)
            CMD_NONE: emit = 1'b1;
            CMD_BEGIN: begin
              emit = 1'b1;
              if (n_ok) begin
                emit_md = '0;
              end else begin
                emit_kind = KIND_BADSET;
              end
            end
            default: begin
              if (!started || !n_ok) begin
                emit      = 1'b1;
                emit_kind = KIND_BADSET;
              end else if (err_hold) begin
                emit      = 1'b1;
                emit_kind = KIND_SPLIT;
              end else if (cmd_c == CMD_ORBIT && mc_full) begin
                emit = 1'b1;
              end
            end
          endcase
        end
      end
      S_DECIDE: begin
        if (cnt != 2'd2) begin
          emit      = 1'b1;
          emit_kind = (cnt == 2'd3) ? KIND_SPLIT : KIND_ACCEPT;
        end
      end
      S_MERGE_A: wr.en = 1'b1;
      S_MERGE_B: begin
        wr.en     = 1'b1;
        wr.addr   = mr;
        emit      = 1'b1;
        emit_kind = KIND_MERGE;
        emit_l    = ml;
        emit_r    = mr;
        emit_res  = res;
        emit_md   = mc + 5'd1;
        emit_last = !is_finish;
      end
      S_FCHECK: begin
        if (mc_full) begin
          emit      = 1'b1;
          emit_kind = KIND_DONE;
        end
      end
      S_SCAN: begin
        if (!(active[scan] && have_a) && scan == 6'd62) begin
          emit      = 1'b1;
          emit_kind = KIND_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pvalid   <= '0;
      active   <= '0;
      mc       <= '0;
      err_hold <= 1'b0;
      started  <= 1'b0;
      n        <= 6'd1;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= emit;
      if (cfg_we) begin
        n <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            mask      <= orbit_mask;
            grp       <= '0;
            cnt       <= '0;
            is_finish <= (cmd_c == CMD_FINISH);
            if (cmd_c == CMD_BEGIN && n_ok) begin
              pvalid   <= '0;
              active   <= active_init;
              mc       <= '0;
              err_hold <= 1'b0;
              started  <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (all_done) begin
            cnt <= cnt_f;
            r0  <= r0_f;
            r1  <= r1_f;
            grp <= grp + GRP_W'(1);
          end
        end
        S_DECIDE: begin
          ml <= r0;
          mr <= r1;
          if (cnt == 2'd3) begin
            err_hold <= 1'b1;
          end
        end
        S_MERGE_B: begin
          pvalid <= (pvalid | (64'd1 << ml) | (64'd1 << mr)) & ~(64'd1 << res);
          active <= (active & ~((63'd1 << ml) | (63'd1 << mr))) | (63'd1 << res);
          mc     <= mc + 5'd1;
        end
        S_FCHECK: begin
          scan   <= '0;
          have_a <= 1'b0;
        end
        S_SCAN: begin
          scan <= scan + 6'd1;
          if (active[scan]) begin
            if (!have_a) begin
              ml     <= scan;
              have_a <= 1'b1;
            end else begin
              mr <= scan;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind        <= emit_kind;
    left_node   <= emit_l;
    right_node  <= emit_r;
    result_node <= emit_res;
    merges_done <= emit_md;
    last        <= emit_last;
  end

endmodule
